### src/pcas_pkg.sv
// ----------------------------------------------------------------------------
// pcas_pkg
// Shared types, codes and channel arithmetic for the palette colour
// add / subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pcas_pkg;

    localparam int PALETTE_ENTRIES   = 256;
    localparam int PAL_ADDR_W        = 8;
    localparam int COLOR_W           = 15;
    localparam int CHAN_W            = 5;
    localparam int CHAN_COUNT        = 3;
    localparam int LAYER_W           = 3;
    localparam int NUM_LAYERS        = 6;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 15;
    localparam int IN_TDATA_W        = 40;
    localparam int OUT_TDATA_W       = 16;
    localparam int SPRITE_PASS_LIMIT = 192;

    localparam logic [LAYER_W-1:0] SPRITE_LAYER = 3'd4;
    localparam logic [CHAN_W-1:0]  CHAN_MAX     = 5'd31;

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_BLEND = 2'd1,
        KIND_FIXED = 2'd2,
        KIND_NONE  = 2'd3
    } pcas_kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SUBTRACT_MODE     = 3'd0,
        REG_HALVE_ENABLE      = 3'd1,
        REG_LAYER_MATH_ENABLE = 3'd2,
        REG_FIXED_COLOR       = 3'd3,
        REG_FIXED_SOURCE_MODE = 3'd4
    } pcas_reg_t;

    // Control of the read stage handed to the colour math stage
    typedef struct packed {
        logic valid;
        logic pass;
        logic fixed;
        logic halve;
    } pcas_ctl_t;

    // Add or subtract one 5:5:5 colour pair, per channel, with optional halving
    function automatic logic [COLOR_W-1:0] blend_color(
        input logic [COLOR_W-1:0] dst,
        input logic [COLOR_W-1:0] src,
        input logic               sub,
        input logic               half
    );
        logic [COLOR_W-1:0] res;
        logic [CHAN_W-1:0]  d;
        logic [CHAN_W-1:0]  s;
        logic [CHAN_W:0]    sum;
        logic [CHAN_W:0]    diff;
        logic [CHAN_W-1:0]  r;
        res = '0;
        for (int c = 0; c < CHAN_COUNT; c++) begin
            d    = dst[c*CHAN_W +: CHAN_W];
            s    = src[c*CHAN_W +: CHAN_W];
            sum  = {1'b0, d} + {1'b0, s};
            diff = {1'b0, d} - {1'b0, s};
            if (sub) begin
                r = diff[CHAN_W] ? '0 : diff[CHAN_W-1:0];
                if (half) begin
                    r = {1'b0, r[CHAN_W-1:1]};
                end
            end else if (half) begin
                r = sum[CHAN_W:1];
            end else begin
                r = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
            end
            res[c*CHAN_W +: CHAN_W] = r;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### src/pcas_palette_mem.sv
// ----------------------------------------------------------------------------
// pcas_palette_mem
// Palette store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcas_palette_mem
    import pcas_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [PAL_ADDR_W-1:0] waddr,
    input  wire logic [COLOR_W-1:0]    wdata,
    input  wire logic                  re,
    input  wire logic [PAL_ADDR_W-1:0] raddr_a,
    input  wire logic [PAL_ADDR_W-1:0] raddr_b,
    output logic      [COLOR_W-1:0]    rdata_a,
    output logic      [COLOR_W-1:0]    rdata_b
);

    logic [COLOR_W-1:0] mem [PALETTE_ENTRIES];
    logic [COLOR_W-1:0] rdata_a_reg;
    logic [COLOR_W-1:0] rdata_b_reg;

    // Store a palette write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read both entries, hold the data while the stage stalls
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

### src/pcas_color_math.sv
// ----------------------------------------------------------------------------
// pcas_color_math
// Channel add / subtract / halve on the read colours and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcas_color_math
    import pcas_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pcas_ctl_t          ctl,
    input  wire logic [COLOR_W-1:0] dst_color,
    input  wire logic [COLOR_W-1:0] src_color,
    input  wire logic [COLOR_W-1:0] fixed_color,
    input  wire logic               subtract_mode,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic      [COLOR_W-1:0] out_color,
    output logic                    free
);

    logic               valid_reg;
    logic               valid_next;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;
    logic [COLOR_W-1:0] src_sel;

    // Output register may load when empty or being drained
    assign free = !valid_reg || out_ready;

    // Pick the source and do the channel math
    always_comb
    begin
        src_sel    = ctl.fixed ? fixed_color : src_color;
        color_next = ctl.pass ? dst_color
                              : blend_color(dst_color, src_sel, subtract_mode, ctl.halve);
        valid_next = free ? ctl.valid : valid_reg;
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && ctl.valid)
        begin
            color_reg <= color_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_color = color_reg;

endmodule

`default_nettype wire

### src/palette_color_add_subtract_unit.sv
// ----------------------------------------------------------------------------
// palette_color_add_subtract_unit
// 256-entry 5:5:5 palette with add / subtract / halve colour math.
// ----------------------------------------------------------------------------
// Path: an accepted blend request is read from the palette into the read stage,
//   then colour math loads the output register that drives m_tvalid.
// Throughput: one request per cycle unless the output stalls; two read ports
//   and one write port mean a write and both blend reads never compete.
// Reset: clears the configuration registers and all valid flags; palette
//   contents are undefined until written.
`default_nettype none

module palette_color_add_subtract_unit
    import pcas_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Request stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [7:0] dest_index, [10:8] dest_layer, [18:11] source_index,
    // [33:19] write_color, [39:34] zero
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  wire logic [1:0]             s_tuser,
    // Result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [14:0] blended_color, [15] zero
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    // Configuration writes
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data
);

    logic [PAL_ADDR_W-1:0] dest_index;
    logic [LAYER_W-1:0]    dest_layer;
    logic [PAL_ADDR_W-1:0] source_index;
    logic [COLOR_W-1:0]    write_color;
    pcas_kind_t            kind;

    logic                   subtract_mode_reg;
    logic                   halve_enable_reg;
    logic [NUM_LAYERS-1:0]  layer_math_enable_reg;
    logic [COLOR_W-1:0]     fixed_color_reg;
    logic                   fixed_source_mode_reg;

    pcas_ctl_t ctl_reg;
    pcas_ctl_t ctl_next;

    logic               accept;
    logic               is_blend;
    logic               math_free;
    logic               layer_en;
    logic [7:0]         layer_bits;
    logic [COLOR_W-1:0] dst_color;
    logic [COLOR_W-1:0] src_color;
    logic               out_valid;
    logic [COLOR_W-1:0] out_color;

    // Unpack the request
    assign dest_index   = s_tdata[7:0];
    assign dest_layer   = s_tdata[10:8];
    assign source_index = s_tdata[18:11];
    assign write_color  = s_tdata[33:19];
    assign kind         = pcas_kind_t'(s_tuser);

    // Take a request whenever the read stage is empty or moving on
    assign s_tready = !ctl_reg.valid || math_free;
    assign accept   = s_tvalid && s_tready;
    assign is_blend = (kind == KIND_BLEND) || (kind == KIND_FIXED);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subtract_mode_reg     <= 1'b0;
            halve_enable_reg      <= 1'b0;
            layer_math_enable_reg <= '0;
            fixed_color_reg       <= '0;
            fixed_source_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SUBTRACT_MODE:     subtract_mode_reg     <= wr_data[0];
                REG_HALVE_ENABLE:      halve_enable_reg      <= wr_data[0];
                REG_LAYER_MATH_ENABLE: layer_math_enable_reg <= wr_data[NUM_LAYERS-1:0];
                REG_FIXED_COLOR:       fixed_color_reg       <= wr_data[COLOR_W-1:0];
                REG_FIXED_SOURCE_MODE: fixed_source_mode_reg <= wr_data[0];
                default:               ;
            endcase
        end
    end

    // Decide pass-through, fixed source and halving for the request being read
    always_comb
    begin
        layer_bits     = {2'b00, layer_math_enable_reg};
        layer_en       = layer_bits[dest_layer];
        ctl_next       = ctl_reg;
        if (accept)
        begin
            ctl_next.valid = is_blend;
            ctl_next.pass  = (dest_layer == SPRITE_LAYER)
                          && ({1'b0, dest_index} < 9'(SPRITE_PASS_LIMIT));
            ctl_next.fixed = (kind == KIND_FIXED);
            ctl_next.halve = layer_en && halve_enable_reg
                          && !((kind == KIND_FIXED) && fixed_source_mode_reg);
        end
        else if (math_free)
        begin
            ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    pcas_palette_mem u_mem (
        .clk     (clk),
        .we      (accept && (kind == KIND_WRITE)),
        .waddr   (dest_index),
        .wdata   (write_color),
        .re      (accept && is_blend),
        .raddr_a (dest_index),
        .raddr_b (source_index),
        .rdata_a (dst_color),
        .rdata_b (src_color)
    );

    pcas_color_math u_math (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl_reg),
        .dst_color     (dst_color),
        .src_color     (src_color),
        .fixed_color   (fixed_color_reg),
        .subtract_mode (subtract_mode_reg),
        .out_ready     (m_tready),
        .out_valid     (out_valid),
        .out_color     (out_color),
        .free          (math_free)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {1'b0, out_color};

endmodule

`default_nettype wire

### src/pcas_checker.sv
// ----------------------------------------------------------------------------
// pcas_checker
// Port-level checks on the palette colour add / subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pcas_checker
    import pcas_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [1:0]             s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata
);

    logic blend_accept;

    assign blend_accept = s_tvalid && s_tready
                       && ((s_tuser == KIND_BLEND) || (s_tuser == KIND_FIXED));

    // A fresh result must trace back to an accepted blend request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(blend_accept, 2))
        else $error("result appeared without a blend request two cycles earlier");

    // An empty output register never blocks requests
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("request stalled while output register empty");

    // A stalled result holds its colour
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // The pad bit above the colour stays clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[OUT_TDATA_W-1])
        else $error("pad bit of result set");

endmodule

bind palette_color_add_subtract_unit pcas_checker u_pcas_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
